@@ src/imd_pkg.sv @@
// Shared types and constants of the isolated mark detector.
// Holds configuration register indexes, field widths and the line buffer control bundle.
// No dependencies.
package imd_pkg;

	// Field widths fixed by the register map and the stream payloads
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 1;
	localparam int TDATA_W      = 8;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Line buffer control: one read strobe, one write per bit plane
	typedef struct packed {
		logic rd_en;
		logic mark_we;
		logic mark_wdata;
		logic pend_we;
		logic pend_wdata;
	} lb_ctl_t;

endpackage

@@ src/isolated_mark_detector_unit.sv @@
// Top level of the isolated mark detector: raster pixel stream in, one verdict per image out.
// Depends on imd_pkg and imd_line_buf.
//
//   channel   dir  payload                         transfer when
//   s_axis    in   tdata[0] marked                 s_axis_tvalid & s_axis_tready
//   m_axis    out  tdata[0] all_connected          m_axis_tvalid & m_axis_tready
//   cfg       in   cfg_index, cfg_data             cfg_valid & cfg_ready
//
// One pixel per cycle while the input is not stalled. A pixel is registered with its line
// buffer read at the input transfer and retired as stage 1 advances; the verdict lands in
// the output register as the last pixel retires. Input stalls only while the last pixel
// of an image waits on a full output register. The line buffer is not cleared at reset:
// every entry is written by a row before the next row reads it. cfg_ready is always high.
module isolated_mark_detector_unit import imd_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [TDATA_W-1:0]     s_axis_tdata,   // [0] marked, [7:1] unused
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [TDATA_W-1:0]     m_axis_tdata,   // [0] all_connected, [7:1] zero
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	// Configuration: stored as clamped last column and last row
	logic [CW-1:0] w_last_q;
	logic [RW-1:0] h_last_q;
	logic [CW-1:0] w_last_d;
	logic [RW-1:0] h_last_d;
	logic [WIDTH_REG_W-1:0]  w_in;
	logic [HEIGHT_REG_W-1:0] h_in;
	logic cfg_wr;
	logic single_pix;

	// Position of the next pixel
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic in_xfer;
	logic in_last_col;
	logic in_last_row;

	// Stage 1: pixel with its line buffer read
	logic          valid_s1;
	logic          m_s1;
	logic [CW-1:0] col_s1;
	logic          first_col_s1;
	logic          first_row_s1;
	logic          last_col_s1;
	logic          last_row_s1;
	logic          last_s1;
	logic          adv_s1;
	logic          proc;

	// Neighbour state
	logic left_mark_q;
	logic left_pend_q;
	logic edge_pend_q;
	logic failure_q;
	logic mark_rd;
	logic pend_rd;
	logic up;
	logic up_pend;
	logic left_final;
	logic cur_pend;
	logic fail_now;
	lb_ctl_t lb_ctl;

	// Verdict register
	logic out_valid_q;
	logic out_pass_q;

	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign w_in       = cfg_data[WIDTH_REG_W-1:0];
	assign h_in       = cfg_data[HEIGHT_REG_W-1:0];
	assign single_pix = (w_last_q == '0) && (h_last_q == '0);

	// Clamp written sizes into the supported range
	always_comb begin
		if (w_in == '0) begin
			w_last_d = '0;
		end else if (32'(w_in) > MAX_WIDTH) begin
			w_last_d = CW'(MAX_WIDTH - 1);
		end else begin
			w_last_d = CW'(w_in - 1'b1);
		end
		if (h_in == '0) begin
			h_last_d = '0;
		end else if (32'(h_in) > MAX_HEIGHT) begin
			h_last_d = RW'(MAX_HEIGHT - 1);
		end else begin
			h_last_d = RW'(h_in - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= '0;
			h_last_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  w_last_q <= w_last_d;
				REG_IMAGE_HEIGHT: h_last_q <= h_last_d;
				default: ;
			endcase
		end
	end

	// Handshake: stage 1 retires unless its verdict has nowhere to go
	assign last_s1       = last_col_s1 && last_row_s1;
	assign adv_s1        = !(last_s1 && out_valid_q && !m_axis_tready);
	assign proc          = valid_s1 && adv_s1;
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign in_last_col   = (col_q == w_last_q);
	assign in_last_row   = (row_q == h_last_q);

	// Advance the raster position at each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (in_last_col) begin
				col_q <= '0;
				row_q <= in_last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			m_s1         <= s_axis_tdata[0];
			col_s1       <= col_q;
			first_col_s1 <= (col_q == '0);
			first_row_s1 <= (row_q == '0);
			last_col_s1  <= in_last_col;
			last_row_s1  <= in_last_row;
		end
	end

	// Neighbour checks for the pixel in stage 1
	always_comb begin
		up         = !first_row_s1 && mark_rd;
		up_pend    = !first_row_s1 && (last_col_s1 ? edge_pend_q : pend_rd);
		left_final = left_pend_q && !m_s1;
		cur_pend   = m_s1 && !up && !left_mark_q;
		fail_now   = (up_pend && !m_s1) || (last_row_s1 && left_final) ||
		             (last_s1 && cur_pend);
	end

	// Line buffer: read at input transfer, write as stage 1 retires
	always_comb begin
		lb_ctl.rd_en      = in_xfer;
		lb_ctl.mark_we    = proc;
		lb_ctl.mark_wdata = m_s1;
		lb_ctl.pend_we    = proc && !first_col_s1 && !last_row_s1;
		lb_ctl.pend_wdata = left_final;
	end

	imd_line_buf #(
		.DEPTH (MAX_WIDTH)
	) u_line_buf (
		.clk        (clk),
		.ctl        (lb_ctl),
		.rd_addr    (col_q),
		.mark_waddr (col_s1),
		.pend_waddr (col_s1 - 1'b1),
		.mark_rd    (mark_rd),
		.pend_rd    (pend_rd)
	);

	// Update left pixel, last column pending flag and failure flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_mark_q <= 1'b0;
			left_pend_q <= 1'b0;
			edge_pend_q <= 1'b0;
			failure_q   <= 1'b0;
		end else if (cfg_wr) begin
			left_mark_q <= 1'b0;
			left_pend_q <= 1'b0;
			failure_q   <= 1'b0;
		end else if (proc) begin
			left_mark_q <= last_col_s1 ? 1'b0 : m_s1;
			left_pend_q <= last_col_s1 ? 1'b0 : cur_pend;
			if (last_col_s1 && !last_row_s1) begin
				edge_pend_q <= cur_pend;
			end
			failure_q <= last_s1 ? 1'b0 : (failure_q || fail_now);
		end
	end

	// Hold the verdict until the downstream transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && last_s1) begin
			out_pass_q <= !(failure_q || fail_now) && !single_pix;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(TDATA_W-1){1'b0}}, out_pass_q};

	// Input stalls only behind a waiting verdict
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && last_s1 && out_valid_q))
		else $error("input stalled without a waiting verdict");

	// Column position never passes the last column in use
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= w_last_q)
		else $error("column position beyond image width");

	// A single pixel image always fails
	a_single_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && last_s1 && single_pix) |=> !out_pass_q)
		else $error("single pixel image passed");

endmodule

@@ src/imd_line_buf.sv @@
// Line buffer of the isolated mark detector: one row of marks and of pending flags.
// Registered reads with same-edge write forwarding. Depends on imd_pkg.
module imd_line_buf import imd_pkg::*; #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  lb_ctl_t       ctl,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] mark_waddr,
	input  logic [AW-1:0] pend_waddr,
	output logic          mark_rd,
	output logic          pend_rd
);

	logic mark_mem [DEPTH];
	logic pend_mem [DEPTH];
	logic mark_mem_q;
	logic pend_mem_q;
	logic mark_byp_q;
	logic mark_byp_val_q;
	logic pend_byp_q;
	logic pend_byp_val_q;

	// Write the bit planes and read both at the requested column
	always_ff @(posedge clk) begin
		if (ctl.mark_we) begin
			mark_mem[mark_waddr] <= ctl.mark_wdata;
		end
		if (ctl.pend_we) begin
			pend_mem[pend_waddr] <= ctl.pend_wdata;
		end
		if (ctl.rd_en) begin
			mark_mem_q <= mark_mem[rd_addr];
			pend_mem_q <= pend_mem[rd_addr];
		end
	end

	// Capture a write that lands on the read column in the same edge
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			mark_byp_q     <= ctl.mark_we && (mark_waddr == rd_addr);
			mark_byp_val_q <= ctl.mark_wdata;
			pend_byp_q     <= ctl.pend_we && (pend_waddr == rd_addr);
			pend_byp_val_q <= ctl.pend_wdata;
		end
	end

	assign mark_rd = mark_byp_q ? mark_byp_val_q : mark_mem_q;
	assign pend_rd = pend_byp_q ? pend_byp_val_q : pend_mem_q;

endmodule

@@ test/tb_top.sv @@
// Testbench for isolated_mark_detector_unit: directed and random binary images streamed in,
// per-image verdicts checked against a behavioral model of the 4-neighbour isolation test.
// Depends on imd_pkg and isolated_mark_detector_unit.
module tb_top import imd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W = 1024;
	localparam int MAX_H = 4096;

	typedef enum int {PAT_EMPTY, PAT_FULL, PAT_HALF, PAT_SPARSE, PAT_DENSE, PAT_DOMINO} pattern_t;

	// Expected verdicts, computed pixel by pixel from the raster stream
	class verdict_board_t;
		logic [WIDTH_REG_W-1:0]  width_reg;
		logic [HEIGHT_REG_W-1:0] height_reg;
		bit          mark_above [MAX_W];
		bit          pend_above [MAX_W];
		bit          left_mark, left_pend, failed;
		int unsigned col, row;
		bit          verdict_q [$];
		int          errors, pixels, verdicts, passes;

		function new();
			width_reg = 1;
			height_reg = 1;
			errors = 0;
			pixels = 0;
			verdicts = 0;
			passes = 0;
			restart();
		endfunction

		function void restart();
			left_mark = 0;
			left_pend = 0;
			col = 0;
			row = 0;
			failed = 0;
		endfunction

		function int unsigned width_in_use();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_W) return MAX_W;
			return width_reg;
		endfunction

		function int unsigned height_in_use();
			if (height_reg == 0) return 1;
			if (height_reg > MAX_H) return MAX_H;
			return height_reg;
		endfunction

		// Any register write restarts the image; the line buffer keeps its contents
		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_IMAGE_WIDTH) width_reg = data[WIDTH_REG_W-1:0];
			else height_reg = data[HEIGHT_REG_W-1:0];
			restart();
		endfunction

		function void note_pixel(bit m);
			int unsigned w, h, c, r;
			bit up, up_pend, lft, left_final, cur_pend, last_col, last_row;
			w = width_in_use();
			h = height_in_use();
			c = (col >= w) ? w - 1 : col;
			r = (row >= h) ? h - 1 : row;
			last_col = (c == w - 1);
			last_row = (r == h - 1);
			up = 0;
			up_pend = 0;
			lft = 0;
			pixels++;
			if (r > 0) begin
				up = mark_above[c];
				up_pend = pend_above[c];
			end
			// Pixel above gets its lower neighbour now
			if (up_pend && !m) failed = 1;
			// Pixel to the left gets its right neighbour now
			if (c > 0) begin
				left_final = left_pend && !m;
				lft = left_mark;
				if (last_row) begin
					if (left_final) failed = 1;
				end else begin
					pend_above[c-1] = left_final;
				end
			end
			cur_pend = m && !up && !lft;
			mark_above[c] = m;
			if (last_col) begin
				if (last_row) begin
					if (cur_pend) failed = 1;
				end else begin
					pend_above[c] = cur_pend;
				end
				left_mark = 0;
				left_pend = 0;
			end else begin
				left_mark = m;
				left_pend = cur_pend;
			end
			// Advance the raster position; emit a verdict after the last pixel
			if (last_col && last_row) begin
				verdict_q.push_back(!failed && !(w == 1 && h == 1));
				restart();
			end else if (last_col) begin
				col = 0;
				row = r + 1;
			end else begin
				col = c + 1;
				row = r;
			end
		endfunction

		function void check_verdict(logic [TDATA_W-1:0] data);
			bit want;
			verdicts++;
			if (data[0] === 1'b1) passes++;
			if (verdict_q.size() == 0) begin
				$error("unexpected verdict: all_connected actual %0d", data[0]);
				errors++;
				return;
			end
			want = verdict_q.pop_front();
			if (data[0] !== want) begin
				$error("all_connected mismatch: expected %0d, actual %0d", want, data[0]);
				errors++;
			end
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [TDATA_W-1:0]     s_axis_tdata;   // [0] marked, [7:1] ignored
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [TDATA_W-1:0]     m_axis_tdata;   // [0] all_connected, [7:1] zero
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	verdict_board_t sb;
	int             max_gap;
	bit             hold_out;

	isolated_mark_detector_unit u_top (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Hold the run to a bounded time
	initial begin
		#(2_000_000);
		$display("== FAIL ==");
		$finish;
	end

	// Verdict receiver: random back-pressure, plus a long hold on request
	initial begin
		m_axis_tready <= 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin : rx_loop
			int pause;
			pause = $urandom_range(0, max_gap);
			if (pause > 0 || hold_out) begin
				m_axis_tready <= 0;
				repeat (pause) @(posedge clk);
				while (hold_out) @(posedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_verdict(m_axis_tdata);
		end
	end

	task automatic send_pixel(input bit m);
		int gap;
		logic [TDATA_W-1:0] word;
		gap = $urandom_range(0, max_gap);
		word = TDATA_W'($urandom);
		word[0] = m;
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata  <= word;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_pixel(m);
	endtask

	// Send pixels in raster order, bit 0 first
	task automatic send_bits(input logic [31:0] bits, input int n);
		for (int i = 0; i < n; i++) send_pixel(bits[i]);
	endtask

	// Build an image of the size in use and send its first cut pixels (all when cut < 0)
	task automatic send_image(input pattern_t pat, input int cut);
		int w, h, n, k;
		bit img [];
		w = sb.width_in_use();
		h = sb.height_in_use();
		n = w * h;
		img = new[n];
		for (int i = 0; i < n; i++) begin
			case (pat)
				PAT_FULL:   img[i] = 1;
				PAT_HALF:   img[i] = ($urandom_range(0, 1) == 1);
				PAT_SPARSE: img[i] = ($urandom_range(0, 7) == 0);
				PAT_DENSE:  img[i] = ($urandom_range(0, 7) != 0);
				default:    img[i] = 0;
			endcase
		end
		// Dominoes give every mark a neighbour; one flipped pixel may break that
		if (pat == PAT_DOMINO) begin
			for (int r = 0; r < h; r++) begin
				for (int c = 0; c < w; c++) begin
					if (!img[r*w+c] && $urandom_range(0, 1)) begin
						if (c + 1 < w && !img[r*w+c+1] && (r + 1 >= h || $urandom_range(0, 1))) begin
							img[r*w+c] = 1;
							img[r*w+c+1] = 1;
						end else if (r + 1 < h) begin
							img[r*w+c] = 1;
							img[(r+1)*w+c] = 1;
						end
					end
				end
			end
			if ($urandom_range(0, 2) == 0) begin
				k = $urandom_range(0, n - 1);
				img[k] = !img[k];
			end
		end
		if (cut < 0) cut = n;
		for (int i = 0; i < cut && i < n; i++) send_pixel(img[i]);
	endtask

	// Stop offering pixels and let every verdict and in-flight pixel drain
	task automatic wait_idle();
		s_axis_tvalid <= 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
			input bit last_one);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		if (last_one) cfg_valid <= 0;
	endtask

	task automatic resize(input logic [CFG_DATA_W-1:0] wd, input logic [CFG_DATA_W-1:0] hd);
		wait_idle();
		if ($urandom_range(0, 1)) begin
			write_reg(REG_IMAGE_WIDTH, wd, 0);
			write_reg(REG_IMAGE_HEIGHT, hd, 1);
		end else begin
			write_reg(REG_IMAGE_HEIGHT, hd, 0);
			write_reg(REG_IMAGE_WIDTH, wd, 1);
		end
	endtask

	initial begin
		int                    base_pixels, sel;
		bit                    restart_due;
		logic [CFG_DATA_W-1:0] wd, hd;
		pattern_t              pat;

		sb = new();
		max_gap = 3;
		hold_out = 0;
		arst_n <= 0;
		s_axis_tvalid <= 0;
		s_axis_tdata <= '0;
		cfg_valid <= 0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset size is a single pixel, which fails whatever it holds
		send_bits(32'b1, 1);
		send_bits(32'b0, 1);
		// Zero sizes are taken as one
		resize(0, 0);
		send_bits(32'b1, 1);
		// Horizontal pair passes, lone mark fails
		resize(2, 1);
		send_bits(32'b11, 2);
		send_bits(32'b01, 2);
		// Vertical pair passes, lone mark in the last pixel fails
		resize(1, 2);
		send_bits(32'b11, 2);
		send_bits(32'b10, 2);
		// Plus shape passes; isolated mark in the bottom-right corner fails
		resize(3, 3);
		send_bits(32'b010111010, 9);
		resize(3, 2);
		send_bits(32'b100011, 6);
		// A register write in the middle of an image restarts the raster
		resize(2, 2);
		send_bits(32'b1, 1);
		wait_idle();
		write_reg(REG_IMAGE_HEIGHT, 2, 1);
		send_bits(32'b0011, 4);

		// Largest sizes, including values clamped to the maximum, streamed in part
		max_gap = 1;
		resize(1024, 2);
		send_image(PAT_DENSE, 32);
		resize(2047, 1);
		send_image(PAT_DOMINO, 32);
		resize(1, 4096);
		send_image(PAT_FULL, 32);
		resize(1, 8191);
		send_image(PAT_DOMINO, 32);

		// Hold off the verdict side while tiny images keep coming, so the input stalls
		resize(2, 1);
		max_gap = 0;
		fork
			begin
				hold_out <= 1;
				repeat (150) @(posedge clk);
				hold_out <= 0;
			end
			for (int k = 0; k < 24; k++) send_image(PAT_HALF, -1);
		join
		wait_idle();

		// Random images of random small sizes, some abandoned part way
		base_pixels = sb.pixels;
		restart_due = 1;
		while (sb.pixels - base_pixels < 350) begin
			max_gap = ($urandom_range(0, 3) == 0) ? 0 : 12;
			if (restart_due || $urandom_range(0, 3) == 0) begin
				wd = ($urandom_range(0, 15) == 0) ? CFG_DATA_W'($urandom_range(9, 40)) :
					CFG_DATA_W'($urandom_range(0, 8));
				hd = CFG_DATA_W'($urandom_range(0, 8));
				// Bits above the width register are dropped
				if ($urandom_range(0, 3) == 0) wd[12:11] = 2'($urandom_range(0, 3));
				resize(wd, hd);
				restart_due = 0;
			end
			sel = $urandom_range(0, 9);
			pat = (sel < 4) ? PAT_DOMINO : (sel < 6) ? PAT_DENSE : pattern_t'(sel - 6);
			if ($urandom_range(0, 9) == 0) begin
				send_image(pat, $urandom_range(0, sb.width_in_use() * sb.height_in_use() - 1));
				restart_due = 1;
			end else begin
				send_image(pat, -1);
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Checked %0d verdicts (%0d passing) over %0d pixels on small images,",
			sb.verdicts, sb.passes, sb.pixels);
		$display("partial images at clamped maximum sizes, mid-image restarts and an output stall.");
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/imd_pkg.sv
src/imd_line_buf.sv
src/isolated_mark_detector_unit.sv
test/tb_top.sv
